// ===== sv/tcl_pkg.sv =====
// ---------------------------------------------------------------------------
// tcl_pkg
// Shared widths for the tile cache LRU directory.
// ---------------------------------------------------------------------------
package tcl_pkg;

  localparam int KEY_W   = 41;  // zoom(5) / x(18) / y(18)
  localparam int STAMP_W = 32;
  localparam int SLOT_W  = 3;

  typedef logic [KEY_W-1:0]   key_t;
  typedef logic [STAMP_W-1:0] stamp_t;
  typedef logic [SLOT_W-1:0]  slot_t;

endpackage

// ===== sv/tile_cache_lru_lookup.sv =====
// ---------------------------------------------------------------------------
// tile_cache_lru_lookup
// Fully associative LRU tile directory, scanned one entry per cycle by a
// shared key/stamp compare unit.
// ---------------------------------------------------------------------------
//
//  channel | dir | handshake        | word
//  --------+-----+------------------+--------------------------
//  request | in  | start & !busy    | tile_key, now_ms
//  result  | out | done (1 cycle)   | hit, slot, evicted
//
// An accepted word goes through these steps in order: one directory read
// per cycle through the single memory read port, the read latency of the
// registered port, the update of the directory and result registers, then
// the done strobe.
// busy is high from the accept edge until the cycle done is shown; start is
// taken again in that same cycle.
// Reset (rst, synchronous) clears the valid bits and the sequencer; no
// clearing pass is needed. The receiver cannot stall: done is a one-cycle
// strobe and the result registers hold until the next lookup ends.
// ---------------------------------------------------------------------------
module tile_cache_lru_lookup import tcl_pkg::*; #(
  parameter int WAYS = 8
) (
  input  logic   clk,
  input  logic   rst,
  input  logic   start,
  output logic   busy,
  input  key_t   tile_key,
  input  stamp_t now_ms,
  output logic   done,
  output logic   hit,
  output slot_t  slot,
  output logic   evicted
);

  localparam int IW = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam logic [IW-1:0] LAST = IW'(WAYS - 1);

  // sequencer codes
  localparam logic [1:0] S_IDLE  = 2'd0;
  localparam logic [1:0] S_SCAN  = 2'd1;
  localparam logic [1:0] S_WRITE = 2'd2;

  logic [1:0]    state;
  logic          issuing;   // read addresses still going out
  logic [IW-1:0] idx;       // address being read
  logic [IW-1:0] rd_idx;    // address whose data is on the read port
  logic          rd_vld;
  key_t          req_key;
  stamp_t        req_now;

  logic          accept;
  logic          rd_en;
  logic          ent_valid;
  key_t          ent_key;
  stamp_t        ent_stamp;
  logic          sc_hit;
  logic          sc_evict;
  logic [IW-1:0] sel_idx;
  logic          wr_en;

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;
  assign rd_en  = (state == S_SCAN) && issuing;
  assign wr_en  = (state == S_WRITE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      issuing <= 1'b0;
      rd_vld  <= 1'b0;
      done    <= 1'b0;
    end else begin
      done   <= 1'b0;
      rd_vld <= rd_en;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            state   <= S_SCAN;
            issuing <= 1'b1;
          end
        end
        S_SCAN: begin
          if (issuing && idx == LAST) begin
            issuing <= 1'b0;
          end
          // last entry evaluated this cycle
          if (rd_vld && rd_idx == LAST) begin
            state <= S_WRITE;
          end
        end
        S_WRITE: begin
          state <= S_IDLE;
          done  <= 1'b1;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      req_key <= tile_key;
      req_now <= now_ms;
      idx     <= '0;
    end else if (rd_en) begin
      idx <= idx + 1'b1;
    end
    if (rd_en) begin
      rd_idx <= idx;
    end
    if (wr_en) begin
      hit     <= sc_hit;
      slot    <= SLOT_W'(sel_idx);
      evicted <= sc_evict;
    end
  end

  tcl_dir #(
    .WAYS (WAYS),
    .IW   (IW)
  ) u_dir (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (rd_en),
    .rd_addr   (idx),
    .rd_valid  (ent_valid),
    .rd_key    (ent_key),
    .rd_stamp  (ent_stamp),
    .wr_en     (wr_en),
    .wr_key_en (!sc_hit),
    .wr_addr   (sel_idx),
    .wr_key    (req_key),
    .wr_stamp  (req_now)
  );

  tcl_scan #(
    .IW (IW)
  ) u_scan (
    .clk       (clk),
    .clear     (accept),
    .eval      (rd_vld),
    .idx       (rd_idx),
    .ent_valid (ent_valid),
    .ent_key   (ent_key),
    .ent_stamp (ent_stamp),
    .req_key   (req_key),
    .hit       (sc_hit),
    .evict     (sc_evict),
    .sel_idx   (sel_idx)
  );

endmodule

// ===== sv/tcl_dir.sv =====
// ---------------------------------------------------------------------------
// tcl_dir
// Directory storage: key and stamp memories with one registered read port
// and one write port, plus per-entry valid flops.
// ---------------------------------------------------------------------------
module tcl_dir import tcl_pkg::*; #(
  parameter int WAYS = 8,
  parameter int IW   = 3
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          rd_en,
  input  logic [IW-1:0] rd_addr,
  output logic          rd_valid,
  output key_t          rd_key,
  output stamp_t        rd_stamp,
  input  logic          wr_en,
  input  logic          wr_key_en,
  input  logic [IW-1:0] wr_addr,
  input  key_t          wr_key,
  input  stamp_t        wr_stamp
);

  key_t   key_mem   [WAYS];
  stamp_t stamp_mem [WAYS];
  logic [WAYS-1:0] valid;

  // valid bits: cleared by reset, set on fill
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (wr_en && wr_key_en) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      stamp_mem[wr_addr] <= wr_stamp;
      if (wr_key_en) begin
        key_mem[wr_addr] <= wr_key;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_key   <= key_mem[rd_addr];
      rd_stamp <= stamp_mem[rd_addr];
      rd_valid <= valid[rd_addr];
    end
  end

endmodule

// ===== sv/tcl_scan.sv =====
// ---------------------------------------------------------------------------
// tcl_scan
// Shared compare unit: one key compare and one stamp compare per entry,
// accumulating first hit, last empty and oldest entry over a pass.
// ---------------------------------------------------------------------------
module tcl_scan import tcl_pkg::*; #(
  parameter int IW = 3
) (
  input  logic          clk,
  input  logic          clear,
  input  logic          eval,
  input  logic [IW-1:0] idx,
  input  logic          ent_valid,
  input  key_t          ent_key,
  input  stamp_t        ent_stamp,
  input  key_t          req_key,
  output logic          hit,
  output logic          evict,
  output logic [IW-1:0] sel_idx
);

  logic          found;
  logic [IW-1:0] found_idx;
  logic          empty;
  logic [IW-1:0] empty_idx;
  stamp_t        oldest;
  logic [IW-1:0] victim_idx;

  always_ff @(posedge clk) begin
    if (clear) begin
      found <= 1'b0;
      empty <= 1'b0;
    end else if (eval) begin
      if (ent_valid) begin
        if (!found && ent_key == req_key) begin
          found     <= 1'b1;
          found_idx <= idx;
        end
      end else begin
        // ascending pass, so the last one seen is the highest
        empty     <= 1'b1;
        empty_idx <= idx;
      end
      // <= keeps the highest index on equal stamps
      if (idx == '0 || ent_stamp <= oldest) begin
        oldest     <= ent_stamp;
        victim_idx <= idx;
      end
    end
  end

  assign hit     = found;
  assign evict   = !found && !empty;
  assign sel_idx = found ? found_idx : (empty ? empty_idx : victim_idx);

endmodule
